[rtl/afu_pkg.sv]
// Shared types, widths, selector codes and the tanh breakpoint table
// for the activation function unit. No dependencies.
package afu_pkg;

    localparam int DATA_W   = 16;
    localparam int FRAC_BITS = 11;
    localparam int Q_W      = 12;
    localparam int SLOPE_W  = 12;
    localparam int SEG_BITS = 6;
    localparam int DIFF_W   = 8;
    localparam int INTERP_W = 9;
    localparam int PROD_W   = DIFF_W + INTERP_W;
    localparam int SQ_W     = 2 * FRAC_BITS + 1;
    localparam int KIND_W   = 2;

    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_BITS);

    localparam logic [KIND_W-1:0] KIND_RELU    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TANH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SIGMOID = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                neg;
        logic                relu_pos;
        logic [DATA_W-1:0]   raw;
        logic                sat;
        logic [Q_W-1:0]      lo;
        logic [DIFF_W-1:0]   diff;
        logic [INTERP_W-1:0] frac;
    } t_lut_stage;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              relu_pos;
        logic [DATA_W-1:0] act;
        logic [Q_W-1:0]    op_a;
        logic [Q_W-1:0]    op_b;
    } t_mul_stage;

    // Breakpoint k holds tanh(8k/64) in Q11, rounded half up.
    function automatic logic [Q_W-1:0] tanh_bp(input logic [SEG_BITS:0] k);
        logic [Q_W-1:0] v;
        case (k)
            7'd0:    v = 12'd0;
            7'd1:    v = 12'd255;
            7'd2:    v = 12'd502;
            7'd3:    v = 12'd734;
            7'd4:    v = 12'd946;
            7'd5:    v = 12'd1136;
            7'd6:    v = 12'd1301;
            7'd7:    v = 12'd1442;
            7'd8:    v = 12'd1560;
            7'd9:    v = 12'd1657;
            7'd10:   v = 12'd1737;
            7'd11:   v = 12'd1802;
            7'd12:   v = 12'd1854;
            7'd13:   v = 12'd1895;
            7'd14:   v = 12'd1928;
            7'd15:   v = 12'd1954;
            7'd16:   v = 12'd1974;
            7'd17:   v = 12'd1990;
            7'd18:   v = 12'd2003;
            7'd19:   v = 12'd2013;
            7'd20:   v = 12'd2021;
            7'd21:   v = 12'd2027;
            7'd22:   v = 12'd2031;
            7'd23:   v = 12'd2035;
            7'd24:   v = 12'd2038;
            7'd25:   v = 12'd2040;
            7'd26:   v = 12'd2042;
            7'd27:   v = 12'd2043;
            7'd28:   v = 12'd2044;
            7'd29:   v = 12'd2045;
            7'd30:   v = 12'd2046;
            7'd31:   v = 12'd2046;
            7'd32:   v = 12'd2047;
            7'd33:   v = 12'd2047;
            7'd34:   v = 12'd2047;
            7'd35:   v = 12'd2047;
            7'd36:   v = 12'd2047;
            default: v = ONE_Q;
        endcase
        return v;
    endfunction

endpackage

[rtl/afu_lookup.sv]
// First pipeline stage: sign and magnitude of the sample, segment select
// and breakpoint table reads. Depends on afu_pkg.
module afu_lookup (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [afu_pkg::DATA_W-1:0]  i_raw,
    input  logic [afu_pkg::KIND_W-1:0]  i_kind,
    output logic                        o_valid,
    input  logic                        i_ready,
    output afu_pkg::t_lut_stage         o_stage
);
    import afu_pkg::*;

    logic               r_valid;
    t_lut_stage         r_stage;
    t_lut_stage         n_stage;
    logic [DATA_W-1:0]  mag;
    logic               is_sig;
    logic [SEG_BITS-1:0] idx;
    logic [Q_W-1:0]     hi;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        is_sig = (i_kind == KIND_SIGMOID);
        mag = i_raw[DATA_W-1] ? DATA_W'(-i_raw) : i_raw;
        n_stage.kind = i_kind;
        n_stage.neg = i_raw[DATA_W-1];
        n_stage.relu_pos = !i_raw[DATA_W-1] && (i_raw != '0);
        n_stage.raw = i_raw;
        if (is_sig) begin
            n_stage.sat = mag[DATA_W-1];
            idx = mag[DATA_W-2:DATA_W-1-SEG_BITS];
            n_stage.frac = mag[INTERP_W-1:0];
        end else begin
            n_stage.sat = mag[DATA_W-1] | mag[DATA_W-2];
            idx = mag[DATA_W-3:DATA_W-2-SEG_BITS];
            n_stage.frac = {mag[INTERP_W-2:0], 1'b0};
        end
        n_stage.lo = tanh_bp({1'b0, idx});
        hi = tanh_bp({1'b0, idx} + 7'd1);
        n_stage.diff = DIFF_W'(hi - n_stage.lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/afu_interp.sv]
// Second and third pipeline stages: interpolation product, ReLU, tanh or sigmoid
// value, and the operands of the slope multiplier. Depends on afu_pkg.
module afu_interp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  afu_pkg::t_lut_stage i_stage,
    output logic                o_valid,
    input  logic                i_ready,
    output afu_pkg::t_mul_stage o_stage
);
    import afu_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              neg;
        logic              relu_pos;
        logic [DATA_W-1:0] raw;
        logic              sat;
        logic [Q_W-1:0]    lo;
        logic [PROD_W-1:0] prod;
    } t_prod_stage;

    logic              r_v2;
    t_prod_stage       r_s2;
    logic              r_v3;
    t_mul_stage        r_s3;
    t_mul_stage        n_s3;
    logic              rdy3;
    logic [PROD_W-1:0] rnd;
    logic [Q_W-1:0]    t;
    logic [Q_W:0]      s_sum;
    logic [Q_W-1:0]    s;

    assign rdy3 = !r_v3 || i_ready;
    assign o_ready = !r_v2 || rdy3;

    always_comb begin
        rnd = r_s2.prod + PROD_W'(1 << (INTERP_W - 1));
        t = r_s2.sat ? ONE_Q : r_s2.lo + Q_W'(rnd[PROD_W-1:INTERP_W]);
        if (r_s2.neg) begin
            s_sum = {1'b0, ONE_Q} - {1'b0, t} + (Q_W+1)'(1);
        end else begin
            s_sum = {1'b0, ONE_Q} + {1'b0, t} + (Q_W+1)'(1);
        end
        s = s_sum[Q_W:1];
        n_s3.kind = r_s2.kind;
        n_s3.relu_pos = r_s2.relu_pos;
        case (r_s2.kind)
            KIND_TANH: begin
                n_s3.act = r_s2.neg ? DATA_W'(-DATA_W'(t)) : DATA_W'(t);
                n_s3.op_a = t;
                n_s3.op_b = t;
            end
            KIND_SIGMOID: begin
                n_s3.act = DATA_W'(s);
                n_s3.op_a = s;
                n_s3.op_b = ONE_Q - s;
            end
            default: begin
                n_s3.act = r_s2.relu_pos ? r_s2.raw : '0;
                n_s3.op_a = '0;
                n_s3.op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s2.kind <= i_stage.kind;
            r_s2.neg <= i_stage.neg;
            r_s2.relu_pos <= i_stage.relu_pos;
            r_s2.raw <= i_stage.raw;
            r_s2.sat <= i_stage.sat;
            r_s2.lo <= i_stage.lo;
            r_s2.prod <= PROD_W'(i_stage.diff * i_stage.frac);
        end
        if (r_v2 && rdy3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_stage = r_s3;

    a_sig_ops_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_s3.kind == KIND_SIGMOID)
            |-> ({1'b0, r_s3.op_a} + {1'b0, r_s3.op_b} == {1'b0, ONE_Q}))
        else $error("Sigmoid slope operands do not sum to one.");

    a_tanh_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_s3.kind == KIND_TANH)
            |-> (r_s3.op_a == r_s3.op_b && r_s3.op_a <= ONE_Q))
        else $error("Tanh slope operands are inconsistent.");

endmodule

[rtl/afu_slope.sv]
// Fourth and fifth pipeline stages: slope product and final slope, held
// in the output register. Depends on afu_pkg.
module afu_slope (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  afu_pkg::t_mul_stage          i_stage,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [afu_pkg::DATA_W-1:0]   o_act,
    output logic [afu_pkg::SLOPE_W-1:0]  o_slope
);
    import afu_pkg::*;

    logic                  r_v4;
    logic [KIND_W-1:0]     r_kind4;
    logic                  r_pos4;
    logic [DATA_W-1:0]     r_act4;
    logic [SQ_W-1:0]       r_sq4;
    logic                  r_v5;
    logic [DATA_W-1:0]     r_act5;
    logic [SLOPE_W-1:0]    r_slope5;
    logic [SLOPE_W-1:0]    n_slope5;
    logic                  rdy5;
    logic [2*Q_W-1:0]      full_sq;
    logic [SQ_W-1:0]       rnd;

    assign rdy5 = !r_v5 || i_ready;
    assign o_ready = !r_v4 || rdy5;
    assign full_sq = i_stage.op_a * i_stage.op_b;

    always_comb begin
        rnd = r_sq4 + SQ_W'(1 << (FRAC_BITS - 1));
        case (r_kind4)
            KIND_TANH: n_slope5 = ONE_Q - SLOPE_W'(rnd[SQ_W-1:FRAC_BITS]);
            KIND_SIGMOID: n_slope5 = SLOPE_W'(rnd[SQ_W-1:FRAC_BITS]);
            default: n_slope5 = r_pos4 ? ONE_Q : '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v4 <= i_valid;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind4 <= i_stage.kind;
            r_pos4 <= i_stage.relu_pos;
            r_act4 <= i_stage.act;
            r_sq4 <= full_sq[SQ_W-1:0];
        end
        if (r_v4 && rdy5) begin
            r_act5 <= r_act4;
            r_slope5 <= n_slope5;
        end
    end

    assign o_valid = r_v5;
    assign o_act = r_act5;
    assign o_slope = r_slope5;

    a_slope_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_slope5 <= ONE_Q))
        else $error("Slope result exceeds one.");

endmodule

[rtl/activation_function_unit.sv]
// Top level of the activation function unit: selector register, five-stage
// pipeline and stream ports. Depends on afu_pkg, afu_lookup, afu_interp, afu_slope.
//
// Usage:
// The slave stream carries one signed Q4.11 sample per transfer in
// s_axis tdata. The master stream returns the activation value and the
// derivative at that sample. The cfg channel writes the 2-bit selector:
// 0 ReLU, 1 tanh, 2 sigmoid; code 3 acts as ReLU. It is always ready and
// should be written only while no sample is in flight.
// Throughput is one sample per clock while the master side is not stalled.
// Each sample passes through five registered stages in order: magnitude
// and table reads, the interpolation product, the interpolated value,
// the slope product, and the output register.
// When the receiver stalls, results stay in place and empty stages keep
// filling; tready on the slave side drops only once all five stages hold
// data. Synchronous reset empties the pipeline and selects ReLU.
module activation_function_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] activation_out, [27:16] slope_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);
    import afu_pkg::*;

    logic [KIND_W-1:0]  r_kind;
    logic               lut_valid;
    logic               lut_ready;
    t_lut_stage         lut_stage;
    logic               mul_valid;
    logic               mul_ready;
    t_mul_stage         mul_stage;
    logic [DATA_W-1:0]  act;
    logic [SLOPE_W-1:0] slope;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_RELU;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_kind <= i_cfg_data;
        end
    end

    afu_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_raw   (i_s_axis_tdata),
        .i_kind  (r_kind),
        .o_valid (lut_valid),
        .i_ready (lut_ready),
        .o_stage (lut_stage)
    );

    afu_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lut_valid),
        .o_ready (lut_ready),
        .i_stage (lut_stage),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_stage (mul_stage)
    );

    afu_slope u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_stage (mul_stage),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_act   (act),
        .o_slope (slope)
    );

    assign o_m_axis_tdata = {4'b0000, slope, act};

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("Input stalled while the output register is empty.");

endmodule
